/* sv/polynomial_evaluator_top_macros.svh */
// Assertion macros for the polynomial evaluator checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH
`define POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH

// Checked only while out of reset.
`define POLYEV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset cycles included.
`define POLYEV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/polyev_pkg.sv */
// ----------------------------------------------------------------------------
// polyev_pkg
// Shared constants and controller/datapath interface types for the
// polynomial evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package polyev_pkg;

  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  localparam int unsigned TIDX_W  = 5;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned X_W     = 32;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned DEG_W   = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_coef;  // write one coefficient
    logic start;      // seed accumulator for a new evaluation
    logic step_mul;   // form partial products
    logic step_sum;   // combine partial products
    logic step_acc;   // saturate and add next coefficient
    logic push;       // capture result into output register
  } polyev_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic deg_zero;   // effective degree is zero
    logic last_term;  // current step consumes coefficient 0
  } polyev_sts_t;

endpackage

`default_nettype wire

/* sv/polyev_ctrl.sv */
// ----------------------------------------------------------------------------
// polyev_ctrl
// Sequencer for the Horner loop: input handshake, step sequencing and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module polyev_ctrl
  import polyev_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        op,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output polyev_cmd_t      cmd,
  input  wire polyev_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_ACC  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.load_coef = accept && (op == OP_LOAD);
    cmd.start     = accept && (op == OP_EVAL);
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt = sts.deg_zero ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.step_sum = 1'b1;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        cmd.step_acc = 1'b1;
        state_nxt    = sts.last_term ? S_FIN : S_MUL;
      end
      S_FIN: begin
        // hold the finished value until the output register frees up
        if (out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/polyev_dp.sv */
// ----------------------------------------------------------------------------
// polyev_dp
// Coefficient store, degree register and the Horner multiply-add datapath
// (split 64x32 multiply, 96-bit combine, saturating add), plus result register.
// ----------------------------------------------------------------------------
`default_nettype none

module polyev_dp
  import polyev_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire polyev_cmd_t              cmd,
  output polyev_sts_t                   sts,
  input  wire logic                     cfg_valid,
  input  wire logic [DEG_W-1:0]         cfg_degree,
  input  wire logic [TIDX_W-1:0]        term_index,
  input  wire logic signed [COEF_W-1:0] coefficient,
  input  wire logic signed [X_W-1:0]    x_value,
  output logic signed [VAL_W-1:0]       value,
  output logic                          overflow
);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic [COEF_W-1:0]       coef_r [MAX_TERMS];
  logic [DEG_W-1:0]        deg_r;

  logic signed [X_W-1:0]   x_r;
  logic [VAL_W-1:0]        acc_r, acc_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    ovf_r, ovf_nxt;
  logic signed [63:0]      pp_hi_r;
  logic signed [64:0]      pp_lo_r;
  logic [95:0]             sum_r;
  logic [VAL_W-1:0]        val_r;
  logic                    val_ovf_r;

  logic [IDX_W-1:0]        eff_deg;
  logic [IDX_W-1:0]        rd_addr;
  logic [COEF_W-1:0]       rd_coef;
  logic [VAL_W-1:0]        coef_term;
  logic                    mul_sat;
  logic [VAL_W-1:0]        mul_val;
  logic [VAL_W-1:0]        add_raw;
  logic                    add_sat;

  // clamp degree to the top of the store
  always_comb begin
    if (32'(deg_r) > MAX_TERMS - 1) begin
      eff_deg = IDX_W'(MAX_TERMS - 1);
    end else begin
      eff_deg = IDX_W'(deg_r);
    end
  end

  // single read port: seed address on start, next lower term otherwise
  assign rd_addr   = cmd.start ? eff_deg : (idx_r - IDX_W'(1));
  assign rd_coef   = coef_r[rd_addr];
  assign coef_term = {{(VAL_W-COEF_W-16){rd_coef[COEF_W-1]}}, rd_coef, 16'd0};

  assign sts.deg_zero  = (eff_deg == '0);
  assign sts.last_term = (idx_r == IDX_W'(1));

  // floor shift by 16 is a plain slice; saturate if bits above 63 disagree
  assign mul_sat = !((&sum_r[95:79]) || !(|sum_r[95:79]));
  assign mul_val = mul_sat ? (sum_r[95] ? VAL_MIN : VAL_MAX) : sum_r[79:16];
  assign add_raw = mul_val + coef_term;
  assign add_sat = (mul_val[VAL_W-1] == coef_term[VAL_W-1]) &&
                   (add_raw[VAL_W-1] != mul_val[VAL_W-1]);

  always_comb begin
    acc_nxt = acc_r;
    idx_nxt = idx_r;
    ovf_nxt = ovf_r;
    if (cmd.start) begin
      acc_nxt = coef_term;
      idx_nxt = eff_deg;
      ovf_nxt = 1'b0;
    end else if (cmd.step_acc) begin
      if (add_sat) begin
        acc_nxt = mul_val[VAL_W-1] ? VAL_MIN : VAL_MAX;
      end else begin
        acc_nxt = add_raw;
      end
      idx_nxt = idx_r - IDX_W'(1);
      ovf_nxt = ovf_r || mul_sat || add_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
        coef_r[i] <= '0;
      end
      deg_r <= '0;
    end else begin
      if (cmd.load_coef && (32'(term_index) < MAX_TERMS)) begin
        coef_r[IDX_W'(term_index)] <= coefficient;
      end
      if (cfg_valid) begin
        deg_r <= cfg_degree;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= x_value;
    end
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
    ovf_r <= ovf_nxt;
    if (cmd.step_mul) begin
      pp_hi_r <= $signed(acc_r[63:32]) * x_r;
      pp_lo_r <= $signed({1'b0, acc_r[31:0]}) * x_r;
    end
    if (cmd.step_sum) begin
      sum_r <= {pp_hi_r, 32'd0} + {{31{pp_lo_r[64]}}, pp_lo_r};
    end
    if (cmd.push) begin
      val_r     <= acc_r;
      val_ovf_r <= ovf_r;
    end
  end

  assign value    = $signed(val_r);
  assign overflow = val_ovf_r;

endmodule

`default_nettype wire

/* sv/polynomial_evaluator_top.sv */
// ----------------------------------------------------------------------------
// polynomial_evaluator_top
// Horner-rule polynomial evaluator, signed Q16.16 input, saturated Q48.16 out.
// ----------------------------------------------------------------------------
// A load beat (tuser op = 0) writes one coefficient and leaves in_tready high;
// an evaluate beat (op = 1) occupies the block for d Horner steps, d being the
// configured degree, after which in_tready rises again. Each Horner step goes
// through three registers in turn: a 32x32 and a 33x32 partial product of
// acc*x, a 96-bit combine, then the floor/saturate and coefficient add. The
// result sits in an output register, so the next item is taken while it
// waits; an evaluation that finishes while that register is still full holds
// until it drains. The coefficient store is cleared at reset.
`default_nettype none

module polynomial_evaluator_top
  import polyev_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // [4:0] term_index, [20:5] coefficient,
                                       // [52:21] x_value, [55:53] zero
  input  wire logic [0:0]  in_tuser,   // [0] op
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value
  output logic [0:0]       out_tuser,  // [0] overflow
  // degree register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data    // [4:0] degree
);

  polyev_cmd_t              cmd;
  polyev_sts_t              sts;
  logic signed [VAL_W-1:0]  value;
  logic                     overflow;

  assign cfg_ready = 1'b1;

  polyev_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .op         (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  polyev_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_degree  (cfg_data),
    .term_index  (in_tdata[4:0]),
    .coefficient ($signed(in_tdata[20:5])),
    .x_value     ($signed(in_tdata[52:21])),
    .value       (value),
    .overflow    (overflow)
  );

  assign out_tdata    = value;
  assign out_tuser[0] = overflow;

endmodule

`default_nettype wire

/* sv/polyev_chk.sv */
// ----------------------------------------------------------------------------
// polyev_chk
// Port-level checker for the polynomial evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polynomial_evaluator_top_macros.svh"

module polyev_chk
  import polyev_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [0:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // stalled result beat must hold
  `POLYEV_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // reset leaves no result pending and the input open
  `POLYEV_ASSERT_RST(a_rst_clean, !rst_n |=> !out_tvalid && in_tready, "block not idle after reset")

  // a load completes in its own beat
  `POLYEV_ASSERT(a_load_1cyc, in_tvalid && in_tready && (in_tuser[0] == OP_LOAD) |=> in_tready, "load beat stalled the input")

  // an evaluate beat always occupies the block
  `POLYEV_ASSERT(a_eval_busy, in_tvalid && in_tready && (in_tuser[0] == OP_EVAL) |=> !in_tready, "input open right after evaluate")

endmodule

bind polynomial_evaluator_top polyev_chk u_chk (.*);

`default_nettype wire

/* tb/sv/tb_polynomial_evaluator_top.sv */
// ----------------------------------------------------------------------------
// tb_polynomial_evaluator_top
// Self-checking testbench for the Horner-rule polynomial evaluator.
// Coefficient loads and evaluate beats go into the input stream, and the
// degree register is set between phases while the block is idle. A
// scoreboard keeps its own copy of the coefficient store. For every
// evaluate beat it predicts the saturated Q48.16 value and the overflow
// flag, then checks each result beat in order. Phases change the degree and
// the amount of input idling and output back-pressure.
// ----------------------------------------------------------------------------
module tb_polynomial_evaluator_top
  import polyev_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 3 * (MAX_TERMS - 1) + 8;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 106;

  localparam logic signed [127:0] PROD_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] PROD_MIN = -PROD_MAX - 128'sd1;
  localparam logic signed [65:0]  SUM_MAX  = 66'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0]  SUM_MIN  = -SUM_MAX - 66'sd1;

  typedef struct packed {
    logic        ovf;
    logic [63:0] value;
  } poly_result_t;

  class horner_scoreboard;
    logic signed [COEF_W-1:0] coef_store [MAX_TERMS];
    logic [DEG_W-1:0]         degree;
    poly_result_t             expected_q [$];
    int                       errors;

    function void clear_state();
      foreach (coef_store[i]) coef_store[i] = '0;
      degree = '0;
      errors = 0;
      expected_q.delete();
    endfunction

    function void set_degree(logic [DEG_W-1:0] d);
      degree = d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Horner's rule: floor the Q.32 product back to Q.16, saturate, add c[i-1], saturate.
    function poly_result_t eval_poly(logic signed [X_W-1:0] x);
      logic signed [63:0]  acc;
      logic signed [127:0] acc_ext;
      logic signed [127:0] x_ext;
      logic signed [127:0] prod;
      logic signed [65:0]  sum;
      logic signed [65:0]  term;
      int                  eff_deg;
      poly_result_t        res;
      eff_deg = (degree > MAX_TERMS - 1) ? MAX_TERMS - 1 : degree;
      res.ovf = 1'b0;
      acc = {{32{coef_store[eff_deg][COEF_W-1]}}, coef_store[eff_deg], 16'h0000};
      for (int i = eff_deg; i > 0; i--) begin
        acc_ext = acc;
        x_ext = x;
        prod = (acc_ext * x_ext) >>> 16;
        if (prod > PROD_MAX) begin
          prod = PROD_MAX;
          res.ovf = 1'b1;
        end else if (prod < PROD_MIN) begin
          prod = PROD_MIN;
          res.ovf = 1'b1;
        end
        acc = prod[63:0];
        term = {{34{coef_store[i-1][COEF_W-1]}}, coef_store[i-1], 16'h0000};
        sum = acc;
        sum = sum + term;
        if (sum > SUM_MAX) begin
          sum = SUM_MAX;
          res.ovf = 1'b1;
        end else if (sum < SUM_MIN) begin
          sum = SUM_MIN;
          res.ovf = 1'b1;
        end
        acc = sum[63:0];
      end
      res.value = acc;
      return res;
    endfunction

    function void note_input(logic op, logic [TIDX_W-1:0] idx,
                             logic signed [COEF_W-1:0] coef, logic signed [X_W-1:0] x);
      if (op == OP_LOAD) begin
        if (idx < MAX_TERMS) coef_store[idx] = coef;
      end else begin
        expected_q.push_back(eval_poly(x));
      end
    endfunction

    function void check_result(logic [63:0] value, logic ovf);
      poly_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: value %h overflow %0d", value, ovf);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (value !== exp_res.value) begin
        $error("value mismatch: expected %h, actual %h", exp_res.value, value);
        errors++;
      end
      if (ovf !== exp_res.ovf) begin
        $error("overflow mismatch: expected %0d, actual %0d", exp_res.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  horner_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  polynomial_evaluator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check the beat taken at this edge, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(logic op, logic [TIDX_W-1:0] idx,
                           logic signed [COEF_W-1:0] coef, logic signed [X_W-1:0] x);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, x, coef, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, idx, coef, x);
  endtask

  task automatic load_coef(logic [TIDX_W-1:0] idx, logic signed [COEF_W-1:0] coef);
    send_item(OP_LOAD, idx, coef, $urandom);
  endtask

  task automatic eval_at(logic signed [X_W-1:0] x);
    send_item(OP_EVAL, TIDX_W'($urandom), COEF_W'($urandom), x);
  endtask

  // wait for all results, then let a trailing load or evaluation finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_degree(logic [DEG_W-1:0] d);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_degree(d);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    logic                     op;
    logic signed [COEF_W-1:0] coef;
    logic signed [X_W-1:0]    x;
    op = ($urandom_range(99) < 40) ? OP_LOAD : OP_EVAL;
    case ($urandom_range(3))
      0, 1:    coef = COEF_W'($urandom);
      2:       coef = COEF_W'($signed($urandom_range(8)) - 4);
      default: coef = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
    endcase
    case ($urandom_range(3))
      0:       x = $urandom;
      1:       x = $signed($urandom_range(262144)) - 131072;
      2:       x = $signed($urandom_range(65535)) - 32768;
      default: begin
        case ($urandom_range(4))
          0:       x = 32'sh7FFF_FFFF;
          1:       x = -32'sh8000_0000;
          2:       x = 32'sh0001_0000;
          3:       x = -32'sh0001_0000;
          default: x = '0;
        endcase
      end
    endcase
    send_item(op, TIDX_W'($urandom), coef, x);
  endtask

  initial begin
    int phase_deg;
    sb = new;
    sb.clear_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: cleared store, degree 0, then the extremes at degree 31
    eval_at(32'sh0001_0000);
    load_coef(0, -16'sh8000);
    eval_at(32'sh7FFF_FFFF);
    write_degree(31);
    load_coef(31, 16'sh7FFF);
    load_coef(1, -16'sh0001);
    eval_at('0);
    eval_at(32'sh0001_0000);
    eval_at(-32'sh0001_0000);
    eval_at(32'sh7FFF_FFFF);
    eval_at(-32'sh8000_0000);
    eval_at(-32'sh0000_0001);
    eval_at(32'sh0000_0001);
    // negative top coefficient: saturates low, odd power of a negative x high
    load_coef(31, -16'sh8000);
    eval_at(32'sh7FFF_FFFF);
    eval_at(-32'sh8000_0000);
    // degree 1: exact products, then floor of a negative product
    write_degree(1);
    load_coef(1, 16'sh7FFF);
    load_coef(0, 16'sh7FFF);
    eval_at(32'sh7FFF_FFFF);
    eval_at(32'sh0000_8001);
    load_coef(1, -16'sh0001);
    eval_at(32'sh0000_8001);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_deg = 0;
        1, 5:    phase_deg = 31;
        2:       phase_deg = 1;
        6:       phase_deg = 2;
        default: phase_deg = $urandom_range(31);
      endcase
      write_degree(DEG_W'(phase_deg));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/polyev_pkg.sv
sv/polyev_ctrl.sv
sv/polyev_dp.sv
sv/polynomial_evaluator_top.sv
sv/polyev_chk.sv
tb/sv/tb_polynomial_evaluator_top.sv
